@@ rtl/pps_pkg.sv @@
// shared types, constants and codes of the polygon plane splitter
package pps_pkg;

  localparam int PPS_MAX_POINTS  = 32;
  localparam int PPS_ADDR_W      = 5;
  localparam int PPS_DATA_W      = 32;
  localparam int PPS_T_BITS      = 28;
  localparam int PPS_DIV_CNT_W   = 5;
  localparam int PPS_EST_EXTRA   = 4;
  localparam int PPS_HARD_LIMIT  = 64;
  localparam logic signed [15:0] PPS_ONE_Q14 = 16'sd16384;

  localparam logic signed [15:0] PPS_RST_NORMAL_X = 16'sd0;
  localparam logic signed [15:0] PPS_RST_NORMAL_Y = 16'sd0;
  localparam logic signed [15:0] PPS_RST_NORMAL_Z = 16'sd16384;
  localparam logic signed [31:0] PPS_RST_OFFSET   = 32'sd0;
  localparam logic [20:0]        PPS_RST_MARGIN   = 21'd1638;

  typedef enum logic [2:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_MARGIN       = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    SIDE_FRONT = 2'd0,
    SIDE_BACK  = 2'd1,
    SIDE_ON    = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ESTIMATE = 2'd1,
    STAT_HARD     = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic [20:0]        margin;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [33:0] sdist;
    side_e              side;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MUL_X, OP_MUL_Y, OP_MUL_Z, OP_SUM, OP_STORE,
    OP_RD_I, OP_RD_J, OP_LAT_J, OP_DIV_INIT, OP_DIV_STEP,
    OP_XMUL_LO, OP_XMUL_HI, OP_XSUM, OP_XFIN, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] coord;
    logic       crossing;
    logic       to_front;
    logic       to_back;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic  out_busy;
    logic  full;
    logic  front_zero;
    logic  back_zero;
    side_e cur_side;
    side_e nxt_side;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MULX, S_MULY, S_MULZ, S_SUM, S_STORE, S_RDI, S_RDJ, S_LATJ,
    S_EMITV, S_DIVI, S_DIV, S_XLO, S_XHI, S_XSUM, S_XFIN, S_EMITC
  } ctl_state_e;

endpackage

@@ rtl/pps_vtx_if.sv @@
// vertex input channel
interface pps_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

@@ rtl/pps_res_if.sv @@
// split result channel
interface pps_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               to_front;
  logic               to_back;
  logic               last_out;
  logic [1:0]         status;

  modport source (output valid, out_x, out_y, out_z, to_front, to_back, last_out, status,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, to_front, to_back, last_out, status,
                output ready);
endinterface

@@ rtl/pps_cfg.sv @@
// apb register bank holding the plane and margin
module pps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pps_pkg::PPS_ADDR_W-1:0] paddr,
  input  logic [pps_pkg::PPS_DATA_W-1:0] pwdata,
  output logic [pps_pkg::PPS_DATA_W-1:0] prdata,
  output logic                         pready,
  output pps_pkg::cfg_t                cfg_o
);
  import pps_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PPS_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_x     <= PPS_RST_NORMAL_X;
      cfg_q.normal_y     <= PPS_RST_NORMAL_Y;
      cfg_q.normal_z     <= PPS_RST_NORMAL_Z;
      cfg_q.plane_offset <= PPS_RST_OFFSET;
      cfg_q.margin       <= PPS_RST_MARGIN;
    end else if (wr_en) begin
      unique case (idx)
        REG_NORMAL_X:     cfg_q.normal_x     <= pwdata[15:0];
        REG_NORMAL_Y:     cfg_q.normal_y     <= pwdata[15:0];
        REG_NORMAL_Z:     cfg_q.normal_z     <= pwdata[15:0];
        REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata;
        REG_MARGIN:       cfg_q.margin       <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NORMAL_X:     prdata = {16'b0, cfg_q.normal_x};
      REG_NORMAL_Y:     prdata = {16'b0, cfg_q.normal_y};
      REG_NORMAL_Z:     prdata = {16'b0, cfg_q.normal_z};
      REG_PLANE_OFFSET: prdata = cfg_q.plane_offset;
      REG_MARGIN:       prdata = {11'b0, cfg_q.margin};
      default:          prdata = '0;
    endcase
  end
endmodule

@@ rtl/pps_datapath.sv @@
// vertex store, shared multiplier, divider and result register
module pps_datapath #(
  parameter int MAX_POINTS = pps_pkg::PPS_MAX_POINTS,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::cfg_t        cfg_i,
  input  pps_pkg::dp_cmd_t     cmd_i,
  input  logic [IDX_W-1:0]     addr_i,
  input  logic signed [31:0]   vertex_x_i,
  input  logic signed [31:0]   vertex_y_i,
  input  logic signed [31:0]   vertex_z_i,
  output pps_pkg::dp_stat_t    stat_o,
  output logic [CNT_W-1:0]     count_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic signed [31:0]   out_x_o,
  output logic signed [31:0]   out_y_o,
  output logic signed [31:0]   out_z_o,
  output logic                 to_front_o,
  output logic                 to_back_o,
  output logic                 last_out_o,
  output logic [1:0]           status_o
);
  import pps_pkg::*;

  localparam int NF_W  = $clog2(2 * MAX_POINTS + 1);
  localparam int CMP_W = ((NF_W > 7) ? NF_W : 7) + 1;
  localparam int ACC_W = 62;

  entry_t mem [MAX_POINTS];
  entry_t rd_q, cur_q, nxt_q;

  logic signed [31:0] vx_q, vy_q, vz_q;
  logic [CNT_W-1:0]   vcnt_q, fcnt_q, bcnt_q;
  logic               ovf_q;
  logic [NF_W-1:0]    nf_q, nb_q;

  logic signed [50:0]      p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [34:0]             den_q;
  logic [35:0]             rem_q;
  logic [PPS_T_BITS-1:0]   t_q;
  logic signed [31:0]      cx_q [3];

  logic                    out_valid_q;
  logic signed [31:0]      ox_q, oy_q, oz_q;
  logic                    of_q, ob_q, ol_q;
  logic [1:0]              os_q;

  // multiplier operands
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [31:0] pi, pj;
  logic signed [15:0] nc;
  logic signed [32:0] diff;

  always_comb begin
    case (cmd_i.coord)
      2'd0:    begin pi = cur_q.x; pj = nxt_q.x; nc = cfg_i.normal_x; end
      2'd1:    begin pi = cur_q.y; pj = nxt_q.y; nc = cfg_i.normal_y; end
      default: begin pi = cur_q.z; pj = nxt_q.z; nc = cfg_i.normal_z; end
    endcase
    diff = {pj[31], pj} - {pi[31], pi};
    case (cmd_i.op)
      OP_MUL_X: begin
        mul_a = {{2{vx_q[31]}}, vx_q};
        mul_b = {cfg_i.normal_x[15], cfg_i.normal_x};
      end
      OP_MUL_Y: begin
        mul_a = {{2{vy_q[31]}}, vy_q};
        mul_b = {cfg_i.normal_y[15], cfg_i.normal_y};
      end
      OP_MUL_Z: begin
        mul_a = {{2{vz_q[31]}}, vz_q};
        mul_b = {cfg_i.normal_z[15], cfg_i.normal_z};
      end
      OP_XMUL_LO: begin
        mul_a = {diff[32], diff};
        mul_b = {3'b0, t_q[13:0]};
      end
      default: begin
        mul_a = {diff[32], diff};
        mul_b = {3'b0, t_q[27:14]};
      end
    endcase
  end

  // plane distance from the accumulated dot product, saturated to 34 bits
  logic signed [47:0] dq;
  logic signed [48:0] dwide;
  logic signed [33:0] dsat;
  logic signed [34:0] dcmp, mpos, mneg;
  side_e              new_side;

  always_comb begin
    dq    = acc_q[61:14];
    dwide = {dq[47], dq} - {{17{cfg_i.plane_offset[31]}}, cfg_i.plane_offset};
    if (dwide[48:33] == {16{dwide[48]}}) begin
      dsat = dwide[33:0];
    end else begin
      dsat = dwide[48] ? {1'b1, 33'b0} : {1'b0, {33{1'b1}}};
    end
    dcmp = {dsat[33], dsat};
    mpos = {14'b0, cfg_i.margin};
    mneg = -mpos;
    if (dcmp > mpos) begin
      new_side = SIDE_FRONT;
    end else if (dcmp < mneg) begin
      new_side = SIDE_BACK;
    end else begin
      new_side = SIDE_ON;
    end
  end

  // crossing fraction and coordinate
  logic [33:0]        ai, aj;
  logic [35:0]        r2;
  logic               ge;
  logic signed [33:0] qstep;
  logic signed [31:0] xcoord;

  always_comb begin
    ai = cur_q.sdist[33] ? 34'(-cur_q.sdist) : cur_q.sdist;
    aj = nxt_q.sdist[33] ? 34'(-nxt_q.sdist) : nxt_q.sdist;
    r2 = {rem_q[34:0], 1'b0};
    ge = r2 >= {1'b0, den_q};
    // truncate toward zero
    qstep = acc_q[61:28] + 34'(acc_q[61] && (acc_q[27:0] != '0));
    if (nc == PPS_ONE_Q14) begin
      xcoord = cfg_i.plane_offset;
    end else if (nc == -PPS_ONE_Q14) begin
      xcoord = (cfg_i.plane_offset == {1'b1, 31'b0}) ? {1'b0, {31{1'b1}}}
                                                     : -cfg_i.plane_offset;
    end else begin
      xcoord = pi + qstep[31:0];
    end
  end

  // side counts and status of the final result
  logic [NF_W-1:0]  nf_d, nb_d;
  logic [CMP_W-1:0] est;
  status_e          fin_status;

  always_comb begin
    nf_d = nf_q + NF_W'(cmd_i.to_front);
    nb_d = nb_q + NF_W'(cmd_i.to_back);
    est  = CMP_W'(vcnt_q) + CMP_W'(PPS_EST_EXTRA);
    if (ovf_q) begin
      fin_status = STAT_OVERFLOW;
    end else if (CMP_W'(nf_d) > est || CMP_W'(nb_d) > est) begin
      fin_status = STAT_ESTIMATE;
    end else if (CMP_W'(nf_d) > CMP_W'(PPS_HARD_LIMIT) ||
                 CMP_W'(nb_d) > CMP_W'(PPS_HARD_LIMIT)) begin
      fin_status = STAT_HARD;
    end else begin
      fin_status = STAT_OK;
    end
  end

  logic full;
  assign full = (vcnt_q == CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STORE) begin
      mem[vcnt_q[IDX_W-1:0]] <= '{x: vx_q, y: vy_q, z: vz_q, sdist: dsat, side: new_side};
    end
    if (cmd_i.op == OP_RD_I || cmd_i.op == OP_RD_J) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && !full) begin
      vx_q <= vertex_x_i;
      vy_q <= vertex_y_i;
      vz_q <= vertex_z_i;
    end
    if (cmd_i.op == OP_MUL_X || cmd_i.op == OP_MUL_Y || cmd_i.op == OP_MUL_Z ||
        cmd_i.op == OP_XMUL_LO || cmd_i.op == OP_XMUL_HI) begin
      p_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      OP_MUL_Y, OP_XMUL_HI: acc_q <= ACC_W'(p_q);
      OP_MUL_Z, OP_SUM:     acc_q <= acc_q + ACC_W'(p_q);
      OP_XSUM:              acc_q <= acc_q + $signed(ACC_W'({p_q, 14'b0}));
      default: ;
    endcase
    if (cmd_i.op == OP_RD_J) cur_q <= rd_q;
    if (cmd_i.op == OP_LAT_J) nxt_q <= rd_q;
    if (cmd_i.op == OP_DIV_INIT) begin
      den_q <= {1'b0, ai} + {1'b0, aj};
      rem_q <= {2'b0, ai};
      t_q   <= '0;
    end
    if (cmd_i.op == OP_DIV_STEP) begin
      rem_q <= ge ? (r2 - {1'b0, den_q}) : r2;
      t_q   <= {t_q[PPS_T_BITS-2:0], ge};
    end
    if (cmd_i.op == OP_XFIN) cx_q[cmd_i.coord] <= xcoord;
    if (cmd_i.op == OP_EMIT) begin
      ox_q <= cmd_i.crossing ? cx_q[0] : cur_q.x;
      oy_q <= cmd_i.crossing ? cx_q[1] : cur_q.y;
      oz_q <= cmd_i.crossing ? cx_q[2] : cur_q.z;
      of_q <= cmd_i.to_front;
      ob_q <= cmd_i.to_back;
      ol_q <= cmd_i.last;
      os_q <= cmd_i.last ? fin_status : STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= '0;
      fcnt_q      <= '0;
      bcnt_q      <= '0;
      ovf_q       <= 1'b0;
      nf_q        <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_LOAD && full) ovf_q <= 1'b1;
      if (cmd_i.op == OP_STORE) begin
        vcnt_q <= vcnt_q + 1'b1;
        if (new_side == SIDE_FRONT) fcnt_q <= fcnt_q + 1'b1;
        if (new_side == SIDE_BACK) bcnt_q <= bcnt_q + 1'b1;
      end
      if (cmd_i.op == OP_EMIT) begin
        if (cmd_i.last) begin
          vcnt_q <= '0;
          fcnt_q <= '0;
          bcnt_q <= '0;
          ovf_q  <= 1'b0;
          nf_q   <= '0;
          nb_q   <= '0;
        end else begin
          nf_q   <= nf_d;
          nb_q   <= nb_d;
        end
      end
    end
  end

  assign stat_o.out_busy   = out_valid_q && !res_ready_i;
  assign stat_o.full       = full;
  assign stat_o.front_zero = (fcnt_q == '0);
  assign stat_o.back_zero  = (bcnt_q == '0);
  assign stat_o.cur_side   = cur_q.side;
  assign stat_o.nxt_side   = nxt_q.side;
  assign count_o           = vcnt_q;

  assign res_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign to_front_o  = of_q;
  assign to_back_o   = ob_q;
  assign last_out_o  = ol_q;
  assign status_o    = os_q;
endmodule

@@ rtl/pps_ctrl.sv @@
// sequencer for loading, classing and the split walk
module pps_ctrl #(
  parameter int MAX_POINTS = pps_pkg::PPS_MAX_POINTS,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vtx_valid_i,
  input  logic               vtx_last_i,
  output logic               vtx_ready_o,
  input  pps_pkg::dp_stat_t  stat_i,
  input  logic [CNT_W-1:0]   count_i,
  output pps_pkg::dp_cmd_t   cmd_o,
  output logic [IDX_W-1:0]   addr_o
);
  import pps_pkg::*;

  ctl_state_e               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [PPS_DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [1:0]               coord_q, coord_d;
  logic                     last_q, last_d;

  logic             trivial, is_cross, at_end;
  logic [IDX_W-1:0] jdx;

  always_comb begin
    trivial  = stat_i.front_zero || stat_i.back_zero;
    at_end   = (CNT_W'(idx_q) + 1'b1 == count_i);
    jdx      = at_end ? '0 : IDX_W'(idx_q + 1'b1);
    is_cross = !trivial && stat_i.cur_side != SIDE_ON && stat_i.nxt_side != SIDE_ON &&
               stat_i.cur_side != stat_i.nxt_side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      dcnt_q  <= '0;
      coord_q <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
      coord_q <= coord_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    dcnt_d      = dcnt_q;
    coord_d     = coord_q;
    last_d      = last_q;
    vtx_ready_o = 1'b0;
    addr_o      = idx_q;
    cmd_o       = '{op: OP_NOP, coord: coord_q, crossing: 1'b0, to_front: 1'b0,
                    to_back: 1'b0, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        vtx_ready_o = 1'b1;
        if (vtx_valid_i) begin
          cmd_o.op = OP_LOAD;
          last_d   = vtx_last_i;
          idx_d    = '0;
          if (!stat_i.full) begin
            state_d = S_MULX;
          end else if (vtx_last_i) begin
            state_d = S_RDI;
          end
        end
      end
      S_MULX: begin cmd_o.op = OP_MUL_X; state_d = S_MULY; end
      S_MULY: begin cmd_o.op = OP_MUL_Y; state_d = S_MULZ; end
      S_MULZ: begin cmd_o.op = OP_MUL_Z; state_d = S_SUM; end
      S_SUM:  begin cmd_o.op = OP_SUM; state_d = S_STORE; end
      S_STORE: begin
        cmd_o.op = OP_STORE;
        state_d  = last_q ? S_RDI : S_IDLE;
      end
      S_RDI: begin cmd_o.op = OP_RD_I; state_d = S_RDJ; end
      S_RDJ: begin
        cmd_o.op = OP_RD_J;
        addr_o   = jdx;
        state_d  = S_LATJ;
      end
      S_LATJ: begin cmd_o.op = OP_LAT_J; state_d = S_EMITV; end
      S_EMITV: begin
        if (trivial) begin
          cmd_o.to_front = !stat_i.front_zero;
          cmd_o.to_back  = stat_i.front_zero;
        end else begin
          cmd_o.to_front = (stat_i.cur_side != SIDE_BACK);
          cmd_o.to_back  = (stat_i.cur_side != SIDE_FRONT);
        end
        cmd_o.last = at_end && !is_cross;
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          if (is_cross) begin
            state_d = S_DIVI;
          end else if (at_end) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = IDX_W'(idx_q + 1'b1);
            state_d = S_RDI;
          end
        end
      end
      S_DIVI: begin
        cmd_o.op = OP_DIV_INIT;
        dcnt_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        dcnt_d   = dcnt_q + 1'b1;
        if (dcnt_q == PPS_DIV_CNT_W'(PPS_T_BITS - 1)) begin
          coord_d = '0;
          state_d = S_XLO;
        end
      end
      S_XLO:  begin cmd_o.op = OP_XMUL_LO; state_d = S_XHI; end
      S_XHI:  begin cmd_o.op = OP_XMUL_HI; state_d = S_XSUM; end
      S_XSUM: begin cmd_o.op = OP_XSUM; state_d = S_XFIN; end
      S_XFIN: begin
        cmd_o.op = OP_XFIN;
        if (coord_q == 2'd2) begin
          state_d = S_EMITC;
        end else begin
          coord_d = coord_q + 1'b1;
          state_d = S_XLO;
        end
      end
      S_EMITC: begin
        cmd_o.crossing = 1'b1;
        cmd_o.to_front = 1'b1;
        cmd_o.to_back  = 1'b1;
        cmd_o.last     = at_end;
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          if (at_end) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = IDX_W'(idx_q + 1'b1);
            state_d = S_RDI;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_emit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_EMIT |-> !stat_i.out_busy)
    else $error("result written while previous one still waits");

  a_load_goes_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_valid_i && vtx_ready_o && !stat_i.full) |=> state_q == S_MULX)
    else $error("accepted vertex not sent to distance unit");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMITV || state_q == S_EMITC) |-> CNT_W'(idx_q) < count_i)
    else $error("split index beyond stored vertices");

  a_cross_only_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVI |-> !trivial)
    else $error("crossing started on a one-sided polygon");
endmodule

@@ rtl/polygon_plane_splitter.sv @@
// loading: a stored vertex passes MULX, MULY, MULZ, SUM and STORE before the next is taken
// (one shared multiplier does the three normal products in turn); a dropped one skips them
// split: each stored vertex passes RDI, RDJ, LATJ and EMITV (held by output stalls), and a
// crossing adds DIVI, the bit-serial fraction divider, multiplies per coordinate and EMITC
// after the last vertex is stored, RDI, RDJ and LATJ come before the first result in EMITV
// reset clears the state machine, counters and result valid; store and data regs are not
module polygon_plane_splitter #(
  parameter int MAX_POINTS = pps_pkg::PPS_MAX_POINTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pps_vtx_if.sink                         vtx_i,
  pps_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pps_pkg::PPS_ADDR_W-1:0]  paddr,
  input  logic [pps_pkg::PPS_DATA_W-1:0]  pwdata,
  output logic [pps_pkg::PPS_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] addr;
  logic [CNT_W-1:0] count;

  pps_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  pps_ctrl #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk_i,
    .rst_ni,
    .vtx_valid_i (vtx_i.valid),
    .vtx_last_i  (vtx_i.last_vertex),
    .vtx_ready_o (vtx_i.ready),
    .stat_i      (stat),
    .count_i     (count),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  pps_datapath #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .vertex_x_i  (vtx_i.vertex_x),
    .vertex_y_i  (vtx_i.vertex_y),
    .vertex_z_i  (vtx_i.vertex_z),
    .stat_o      (stat),
    .count_o     (count),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .out_x_o     (res_o.out_x),
    .out_y_o     (res_o.out_y),
    .out_z_o     (res_o.out_z),
    .to_front_o  (res_o.to_front),
    .to_back_o   (res_o.to_back),
    .last_out_o  (res_o.last_out),
    .status_o    (res_o.status)
  );
endmodule

@@ tb/tb.sv @@
// testbench of the polygon plane splitter: directed and random polygons against several planes
`timescale 1ns / 100ps

module tb;
  import pps_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 last;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          to_front;
    bit          to_back;
    bit          last_out;
    logic [1:0]  status;
  } split_vtx_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PPS_ADDR_W-1:0] paddr;
  logic [PPS_DATA_W-1:0] pwdata;
  logic [PPS_DATA_W-1:0] prdata;
  logic        pready;

  pps_vtx_if vtx ();
  pps_res_if res ();

  polygon_plane_splitter DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .vtx_i   (vtx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vertex_t    vertex_q[$];
  split_vtx_t split_q[$];

  // plane model state
  cfg_t               plane;
  logic signed [31:0] pt_x[PPS_MAX_POINTS];
  logic signed [31:0] pt_y[PPS_MAX_POINTS];
  logic signed [31:0] pt_z[PPS_MAX_POINTS];
  longint             pt_dist[PPS_MAX_POINTS];
  side_e              pt_side[PPS_MAX_POINTS];
  int                 n_stored;
  int                 n_front;
  int                 n_back;
  bit                 dropped;

  int  mismatches;
  int  n_results;
  int  n_polygons;
  int  n_crossings;
  int  n_bad_status;
  int  idle_pct;
  bit  vtx_taken;
  int  vtx_gap;
  int  rdy_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [31:0] cross_coord(logic signed [15:0] nc,
      logic signed [31:0] pi, logic signed [31:0] pj, longint unsigned t);
    longint diff;
    longint stp;
    if (nc == PPS_ONE_Q14) return plane.plane_offset;
    if (nc == -PPS_ONE_Q14)
      return (plane.plane_offset == 32'sh8000_0000) ? 32'sh7fff_ffff : -plane.plane_offset;
    diff = longint'(pj) - longint'(pi);
    stp  = (diff * longint'(t)) / (64'sd1 <<< 28);
    return 32'(longint'(pi) + stp);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // classify and store one vertex, or drop it when the store is full; the closing vertex emits the split polygon
  task automatic split_vertex(vertex_t v);
    longint            s;
    longint            d;
    longint unsigned   ai;
    longint unsigned   den;
    longint unsigned   t;
    split_vtx_t        outs[$];
    split_vtx_t        r;
    int                j;
    int                nf;
    int                nb;
    bit                f;
    logic [1:0]        st;
    if (n_stored < PPS_MAX_POINTS) begin
      s = longint'(v.x) * plane.normal_x + longint'(v.y) * plane.normal_y
        + longint'(v.z) * plane.normal_z;
      d = (s >>> 14) - longint'(plane.plane_offset);
      if (d > 64'sd8589934591) d = 64'sd8589934591;
      if (d < -64'sd8589934592) d = -64'sd8589934592;
      pt_x[n_stored] = v.x;
      pt_y[n_stored] = v.y;
      pt_z[n_stored] = v.z;
      pt_dist[n_stored] = d;
      if (d > longint'(plane.margin)) begin
        pt_side[n_stored] = SIDE_FRONT;
        n_front++;
      end else if (d < -longint'(plane.margin)) begin
        pt_side[n_stored] = SIDE_BACK;
        n_back++;
      end else begin
        pt_side[n_stored] = SIDE_ON;
      end
      n_stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!v.last) return;
    n_polygons++;
    nf = 0;
    nb = 0;
    if (n_front == 0 || n_back == 0) begin
      f = (n_front != 0);
      for (int i = 0; i < n_stored; i++) begin
        r = '{pt_x[i], pt_y[i], pt_z[i], f, !f, 1'b0, STAT_OK};
        outs.push_back(r);
      end
      nf = f ? n_stored : 0;
      nb = f ? 0 : n_stored;
    end else begin
      for (int i = 0; i < n_stored; i++) begin
        j = (i + 1 < n_stored) ? i + 1 : 0;
        if (pt_side[i] == SIDE_ON) begin
          outs.push_back('{pt_x[i], pt_y[i], pt_z[i], 1'b1, 1'b1, 1'b0, STAT_OK});
          nf++;
          nb++;
          continue;
        end
        outs.push_back('{pt_x[i], pt_y[i], pt_z[i], pt_side[i] == SIDE_FRONT,
                         pt_side[i] == SIDE_BACK, 1'b0, STAT_OK});
        if (pt_side[i] == SIDE_FRONT) nf++; else nb++;
        if (pt_side[j] == SIDE_ON || pt_side[j] == pt_side[i]) continue;
        ai  = magnitude(pt_dist[i]);
        den = ai + magnitude(pt_dist[j]);
        t   = (den != 0) ? (ai << 28) / den : 0;
        outs.push_back('{cross_coord(plane.normal_x, pt_x[i], pt_x[j], t),
                         cross_coord(plane.normal_y, pt_y[i], pt_y[j], t),
                         cross_coord(plane.normal_z, pt_z[i], pt_z[j], t),
                         1'b1, 1'b1, 1'b0, STAT_OK});
        n_crossings++;
        nf++;
        nb++;
      end
    end
    if (dropped) st = STAT_OVERFLOW;
    else if (nf > n_stored + PPS_EST_EXTRA || nb > n_stored + PPS_EST_EXTRA) st = STAT_ESTIMATE;
    else if (nf > PPS_HARD_LIMIT || nb > PPS_HARD_LIMIT) st = STAT_HARD;
    else st = STAT_OK;
    if (st != STAT_OK) n_bad_status++;
    if (outs.size() > 0) begin
      outs[outs.size()-1].last_out = 1'b1;
      outs[outs.size()-1].status   = st;
    end
    foreach (outs[k]) split_q.push_back(outs[k]);
    n_stored = 0;
    n_front  = 0;
    n_back   = 0;
    dropped  = 1'b0;
  endtask

  // sampling side: vertex acceptance feeds the model, results are checked
  always @(posedge clk) begin
    split_vtx_t e;
    if (rst_n) begin
      if (vtx.valid && vtx.ready) begin
        vtx_taken = 1'b1;
        split_vertex('{vtx.vertex_x, vtx.vertex_y, vtx.vertex_z, vtx.last_vertex});
      end
      if (res.valid && res.ready) begin
        n_results++;
        if (split_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result x=%h y=%h z=%h", $realtime,
                     res.out_x, res.out_y, res.out_z);
        end else begin
          e = split_q.pop_front();
          if (res.out_x !== e.x || res.out_y !== e.y || res.out_z !== e.z ||
              res.to_front !== e.to_front || res.to_back !== e.to_back ||
              res.last_out !== e.last_out || res.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch exp %h %h %h f%b b%b l%b s%0d got %h %h %h f%b b%b l%b s%0d",
                       $realtime, e.x, e.y, e.z, e.to_front, e.to_back, e.last_out,
                       e.status, res.out_x, res.out_y, res.out_z, res.to_front,
                       res.to_back, res.last_out, res.status);
          end
        end
      end
    end
  end

  // vertex driver
  always @(negedge clk) begin
    vertex_t v;
    if (rst_n && (!vtx.valid || vtx_taken)) begin
      vtx_taken = 1'b0;
      if (vtx_gap > 0) begin
        vtx_gap--;
        vtx.valid <= 1'b0;
      end else if (vertex_q.size() > 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        vtx_gap = $urandom_range(1, 16) - 1;
        vtx.valid <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        v = vertex_q.pop_front();
        vtx.valid       <= 1'b1;
        vtx.vertex_x    <= v.x;
        vtx.vertex_y    <= v.y;
        vtx.vertex_z    <= v.z;
        vtx.last_vertex <= v.last;
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (rdy_stall > 0) begin
        rdy_stall--;
        res.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        rdy_stall = $urandom_range(1, 16) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PPS_ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NORMAL_X:     plane.normal_x     = value[15:0];
      REG_NORMAL_Y:     plane.normal_y     = value[15:0];
      REG_NORMAL_Z:     plane.normal_z     = value[15:0];
      REG_PLANE_OFFSET: plane.plane_offset = value;
      REG_MARGIN:       plane.margin       = value[20:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(int nx, int ny, int nz, logic [31:0] off, logic [31:0] margin);
    reg_write(REG_NORMAL_X, nx);
    reg_write(REG_NORMAL_Y, ny);
    reg_write(REG_NORMAL_Z, nz);
    reg_write(REG_PLANE_OFFSET, off);
    reg_write(REG_MARGIN, margin);
  endtask

  function automatic logic signed [31:0] near_coord();
    logic [31:0] c;
    int          k;
    k = $urandom_range(4, 24);
    c = $urandom & ((32'd1 << k) - 1);
    return $urandom_range(0, 1) ? -c : c;
  endfunction

  // shape: 0 full range, 1 near origin, 2 zigzag across z, 3 zigzag across x
  task automatic add_polygon(int n, int shape);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      if (shape == 0) begin
        v.x = $urandom;
        v.y = $urandom;
        v.z = $urandom;
      end else begin
        v.x = near_coord();
        v.y = near_coord();
        v.z = near_coord();
      end
      if (shape == 2)
        v.z = (i % 2) ? -(v.z & 32'h00ff_ffff) - 32'h40000
                      : (v.z & 32'h00ff_ffff) + 32'h40000;
      if (shape == 3)
        v.x = (i % 2) ? -(v.x & 32'h00ff_ffff) - 32'h40000
                      : (v.x & 32'h00ff_ffff) + 32'h40000;
      v.last = (i == n - 1);
      vertex_q.push_back(v);
    end
  endtask

  task automatic add_vertex(int x, int y, int z, bit last);
    vertex_q.push_back('{x, y, z, last});
  endtask

  task automatic random_polygons(int count);
    int r;
    for (int p = 0; p < count; p++) begin
      r = $urandom_range(0, 9);
      if (r < 5) add_polygon($urandom_range(3, 8), 1);
      else if (r < 7) add_polygon($urandom_range(3, 10), 2);
      else if (r < 8) add_polygon($urandom_range(3, 8), 3);
      else add_polygon($urandom_range(1, 8), 0);
    end
  endtask

  task automatic drain();
    while (vertex_q.size() > 0 || vtx.valid || split_q.size() > 0) @(posedge clk);
    // a trailing vertex without last gives nothing to wait for
    repeat (100) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.last_vertex = 1'b0;
    res.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    plane = '{PPS_RST_NORMAL_X, PPS_RST_NORMAL_Y, PPS_RST_NORMAL_Z, PPS_RST_OFFSET,
              PPS_RST_MARGIN};
    n_stored = 0;
    n_front = 0;
    n_back = 0;
    dropped = 1'b0;
    mismatches = 0;
    n_results = 0;
    n_polygons = 0;
    n_crossings = 0;
    n_bad_status = 0;
    vtx_taken = 1'b0;
    vtx_gap = 0;
    rdy_stall = 0;
    idle_pct = 15;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items on the reset plane z = 0
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_vertex(0, 0, 100, 1'b1);                  // crossing with on-plane vertex
    add_vertex(5, 6, 0, 1'b0);
    add_vertex(-5, 7, 1638, 1'b0);
    add_vertex(9, -9, -1638, 1'b1);               // all on plane goes to back
    add_vertex(1, 2, 1639, 1'b0);
    add_vertex(3, 4, 32'h7fff_ffff, 1'b1);        // all front
    add_vertex(1, 2, -1639, 1'b0);
    add_vertex(7, 1, 0, 1'b0);
    add_vertex(3, 4, 32'h8000_0000, 1'b1);        // back plus on-plane
    add_vertex(0, 0, 32'h10000, 1'b1);            // single vertex polygon
    add_vertex(100, 0, 32'h20000, 1'b0);
    add_vertex(0, 100, -32'h20000, 1'b0);
    add_vertex(-100, 0, 32'h20000, 1'b0);
    add_vertex(0, -100, -32'h20000, 1'b1);        // four crossings, within the estimate
    drain();
    random_polygons(3);
    drain();

    // x axis plane, zero margin
    set_plane(16384, 0, 0, near_coord(), 0);
    random_polygons(3);
    drain();

    // negative axis snap with the offset at its most negative, margin 1048576
    idle_pct = 0;
    set_plane(-16384, 0, 16384, 32'h8000_0000, 1048576);
    random_polygons(3);
    add_polygon(8, 0);
    drain();

    // tilted plane and one overflowing polygon
    idle_pct = 25;
    set_plane($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
              $urandom_range(4000, 16383), near_coord(), $urandom_range(0, 4096));
    add_polygon(35, 1);
    random_polygons(2);
    drain();

    set_plane(-16384, 16384, -16384, 32'h7fff_ffff, $urandom_range(0, 1048576));
    random_polygons(2);
    add_polygon(6, 0);
    drain();

    // last stretch runs without idling
    idle_pct = 0;
    set_plane($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
              16384, near_coord(), $urandom_range(0, 20000));
    random_polygons(3);
    drain();

    $display("polygons split: %0d, results checked: %0d, crossings: %0d", n_polygons,
             n_results, n_crossings);
    $display("polygons with error status: %0d, mismatches: %0d", n_bad_status, mismatches);
    if (mismatches == 0 && split_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ polygon_plane_splitter.f @@
rtl/pps_pkg.sv
rtl/pps_vtx_if.sv
rtl/pps_res_if.sv
rtl/pps_cfg.sv
rtl/pps_datapath.sv
rtl/pps_ctrl.sv
rtl/polygon_plane_splitter.sv
tb/tb.sv
